FILE: rtl/m3inv_pkg.sv
package m3inv_pkg;

    // sideband that travels with each matrix through the pipeline
    typedef struct packed {
        logic valid;
        logic singular;
    } m3inv_ctl_t;

endpackage

FILE: rtl/matrix3_inverse.sv
// 3x3 fixed-point matrix inverse by adjugate over determinant
// channels: raise start with a00..a22 for one cycle; busy is always low,
//   so a new transaction can be issued every clock cycle
// results: b00..b22, singular and overflow appear together for exactly
//   one cycle while done is high; the receiver cannot hold them off
// throughput: one matrix per cycle; done follows start through the
//   cofactor stages and the bit-per-stage divider
// pipeline: input register, cofactor products, cofactor differences,
//   determinant partial products, determinant sum, divider normalize,
//   WORD_BITS+1 quotient stages, round
// singular: zero determinant gives zero entries, singular set, no overflow
// overflow: any entry clamped to the signed word limits
// reset: rst_n clears the valid and singular sideband bits; data registers run free
module matrix3_inverse
    import m3inv_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [WORD_BITS-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22,
    output logic                        done,
    output logic signed [WORD_BITS-1:0] b00, b01, b02, b10, b11, b12, b20, b21, b22,
    output logic                        singular,
    output logic                        overflow
);

    localparam int DW = 3 * WORD_BITS + 3;
    localparam int DLAT = WORD_BITS + 3;

    logic cof_valid;
    logic signed [2*WORD_BITS:0] cof [9];
    logic signed [DW-1:0] det;
    logic signed [WORD_BITS-1:0] q [9];
    logic [8:0] ov;
    m3inv_ctl_t ctl_reg [DLAT];

    assign busy = 1'b0;

    m3inv_cof #(.WORD_BITS(WORD_BITS)) u_cof (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .mat      ({a22, a21, a20, a12, a11, a10, a02, a01, a00}),
        .out_valid(cof_valid),
        .cof      (cof),
        .det      (det)
    );

    // nine dividers share one determinant; a zero divisor is masked below
    for (genvar i = 0; i < 9; i++)
    begin : g_div
        m3inv_div #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
            .clk(clk),
            .num(cof[i]),
            .den(det),
            .quo(q[i]),
            .ovf(ov[i])
        );
    end

    // valid and singular ride alongside the divider stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DLAT; i++)
            begin
                ctl_reg[i] <= '0;
            end
        end
        else
        begin
            ctl_reg[0] <= '{valid: cof_valid, singular: det == '0};
            for (int i = 1; i < DLAT; i++)
            begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
    end

    logic sg;
    assign sg = ctl_reg[DLAT-1].singular;
    assign done = ctl_reg[DLAT-1].valid;
    assign singular = sg;
    assign overflow = !sg && (|ov);
    assign b00 = sg ? '0 : q[0];
    assign b01 = sg ? '0 : q[1];
    assign b02 = sg ? '0 : q[2];
    assign b10 = sg ? '0 : q[3];
    assign b11 = sg ? '0 : q[4];
    assign b12 = sg ? '0 : q[5];
    assign b20 = sg ? '0 : q[6];
    assign b21 = sg ? '0 : q[7];
    assign b22 = sg ? '0 : q[8];

endmodule

FILE: rtl/m3inv_cof.sv
// cofactors and determinant, five register stages
module m3inv_cof
    import m3inv_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [9*WORD_BITS-1:0] mat,
    output logic                          out_valid,
    output logic signed [2*WORD_BITS:0]   cof [9],
    output logic signed [3*WORD_BITS+2:0] det
);

    localparam int PW = 2 * WORD_BITS + 1;
    localparam int DW = 3 * WORD_BITS + 3;

    logic signed [WORD_BITS-1:0] a [9];
    logic signed [WORD_BITS-1:0] a_reg [9];
    logic signed [2*WORD_BITS-1:0] pp_reg [18];
    logic signed [PW-1:0] cof_reg [9];
    logic signed [PW-1:0] cof_d1_reg [9];
    logic signed [PW-1:0] cof_d2_reg [9];
    logic signed [WORD_BITS-1:0] r0_reg [3];
    logic signed [WORD_BITS-1:0] r0_q [3];
    logic signed [PW-1:0] plo_reg [3];
    logic signed [PW-1:0] phi_reg [3];
    logic signed [DW-1:0] dsum;
    logic signed [DW-1:0] det_reg;
    logic [4:0] v_reg;

    // cofactor index pairs: entry (k,c) of inverse = col k+1 x col k+2
    function automatic int ix(input int r, input int c);
        return r * 3 + c;
    endfunction

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            a[i] = mat[i*WORD_BITS +: WORD_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a;
        // stage 2: products, u = col k+1, v = col k+2, cross term c
        for (int k = 0; k < 3; k++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                pp_reg[2*(k*3+c)] <=
                    a_reg[ix((c+1)%3, (k+1)%3)] * a_reg[ix((c+2)%3, (k+2)%3)];
                pp_reg[2*(k*3+c)+1] <=
                    a_reg[ix((c+2)%3, (k+1)%3)] * a_reg[ix((c+1)%3, (k+2)%3)];
            end
        end
        for (int c = 0; c < 3; c++)
        begin
            r0_reg[c] <= a_reg[c];
        end
        // stage 3: differences
        for (int i = 0; i < 9; i++)
        begin
            cof_reg[i] <= PW'(pp_reg[2*i]) - PW'(pp_reg[2*i+1]);
        end
        r0_q <= r0_reg;
        // stage 4: first row times first column of inverse, cofactor split
        // into an unsigned low word and a signed high part
        for (int c = 0; c < 3; c++)
        begin
            plo_reg[c] <= r0_q[c] * $signed({1'b0, cof_reg[c*3][WORD_BITS-1:0]});
            phi_reg[c] <= r0_q[c] * $signed(cof_reg[c*3][PW-1:WORD_BITS]);
        end
        // stage 5: determinant, cofactors delayed to match
        det_reg <= dsum;
        cof_d1_reg <= cof_reg;
        cof_d2_reg <= cof_d1_reg;
    end

    always_comb
    begin
        dsum = '0;
        for (int c = 0; c < 3; c++)
        begin
            dsum = dsum + DW'(plo_reg[c]) + (DW'(phi_reg[c]) <<< WORD_BITS);
        end
    end

    assign out_valid = v_reg[4];
    assign cof = cof_d2_reg;
    assign det = det_reg;

endmodule

FILE: rtl/m3inv_div.sv
// pipelined restoring divider with rounding and saturation, one bit a stage
module m3inv_div #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic signed [2*WORD_BITS:0]   num,
    input  logic signed [3*WORD_BITS+2:0] den,
    output logic signed [WORD_BITS-1:0]   quo,
    output logic                          ovf
);

    localparam int DW = 3 * WORD_BITS + 3;
    localparam int NW = 2 * WORD_BITS + 1 + 2 * FRAC_BITS;
    localparam int QB = WORD_BITS + 1;
    localparam int RW = DW + 1;

    logic [NW-1:0] an;
    logic [DW-1:0] ad;
    logic signed [NW-1:0] nsc;

    assign nsc = NW'(num) <<< (2 * FRAC_BITS);
    assign an = nsc[NW-1] ? NW'(-nsc) : NW'(nsc);
    assign ad = den[DW-1] ? DW'(-den) : DW'(den);

    // stage 0: high bits beyond QB quotient bits must be below divisor
    logic [NW-1:0] n_s [QB+1];
    logic [RW-1:0] r_s [QB+1];
    logic [DW-1:0] d_s [QB+1];
    logic [QB-1:0] q_s [QB+1];
    logic neg_s [QB+1];
    logic big_s [QB+1];

    logic [RW-1:0] hi0;
    assign hi0 = RW'(an >> QB);

    always_ff @(posedge clk)
    begin
        n_s[0] <= an;
        d_s[0] <= ad;
        neg_s[0] <= nsc[NW-1] ^ den[DW-1];
        big_s[0] <= hi0 >= RW'(ad);
        r_s[0] <= hi0;
        q_s[0] <= '0;
    end

    for (genvar s = 0; s < QB; s++)
    begin : g_st
        logic [RW-1:0] t;
        logic ge;
        always_comb
        begin
            t = {r_s[s][RW-2:0], n_s[s][QB-1-s]};
            ge = t >= RW'(d_s[s]);
        end
        always_ff @(posedge clk)
        begin
            n_s[s+1] <= n_s[s];
            d_s[s+1] <= d_s[s];
            neg_s[s+1] <= neg_s[s];
            big_s[s+1] <= big_s[s];
            r_s[s+1] <= ge ? t - RW'(d_s[s]) : t;
            q_s[s+1] <= {q_s[s][QB-2:0], ge};
        end
    end

    // final stage: round, sign, saturate
    logic [QB:0] qr;
    logic rup;
    logic sat;
    logic [QB:0] lim;
    always_comb
    begin
        rup = {r_s[QB][RW-2:0], 1'b0} >= RW'(d_s[QB]);
        qr = {1'b0, q_s[QB]} + (QB+1)'(rup);
        lim = neg_s[QB] ? (QB+1)'(1) << (WORD_BITS - 1)
                        : ((QB+1)'(1) << (WORD_BITS - 1)) - 1'b1;
        sat = big_s[QB] | (qr > lim);
    end

    always_ff @(posedge clk)
    begin
        ovf <= sat;
        if (sat)
        begin
            quo <= neg_s[QB] ? {1'b1, {(WORD_BITS-1){1'b0}}}
                             : {1'b0, {(WORD_BITS-1){1'b1}}};
        end
        else
        begin
            quo <= neg_s[QB] ? WORD_BITS'(-qr) : WORD_BITS'(qr);
        end
    end

endmodule

FILE: rtl/m3inv_chk.sv
module m3inv_chk (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic singular,
    input logic overflow
);

    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(singular && overflow))
        else $error("singular with overflow");
    a_reset: assert property (@(posedge clk) $rose(rst_n) |-> !done)
        else $error("done after reset");

endmodule

bind matrix3_inverse m3inv_chk u_chk (.*);
